### rtl/sfr_pkg.sv
package sfr_pkg;

    localparam int LEN_W     = 4;
    localparam int REG_W     = 64;
    localparam int LINE_W    = 31;
    localparam int CFG_IDX_W = 3;

    localparam logic [LINE_W-1:0] LINE_MAX     = '1;
    localparam logic [7:0]        NEWLINE_BYTE = 8'h0A;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIND_LEN   = 3'd0,
        CFG_FIND_PAT   = 3'd1,
        CFG_REPL_LEN   = 3'd2,
        CFG_REPL_TEXT  = 3'd3,
        CFG_FIRST_LINE = 3'd4,
        CFG_LAST_LINE  = 3'd5,
        CFG_FOLD_CASE  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic shift;
        logic fold_case;
    } t_win_ctrl;

    typedef struct packed {
        logic load;
        logic shift;
    } t_out_ctrl;

    // upper-case ascii letters map to lower case when folding
    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
        logic [7:0] r;
        r = b;
        if (en && b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

    function automatic logic byte_eq(input logic [7:0] a, input logic [7:0] b,
                                     input logic en);
        return fold_byte(a, en) == fold_byte(b, en);
    endfunction

endpackage

### rtl/sfr_win_cell.sv
module sfr_win_cell #(
    parameter int PAT_LEN = 8
) (
    input  logic                   i_clk,
    input  sfr_pkg::t_win_ctrl     i_ctrl,
    input  logic [7:0]             i_byte,
    input  logic [8*PAT_LEN-1:0]   i_pattern,
    output logic [7:0]             o_byte,
    output logic [PAT_LEN-1:0]     o_eq
);
    import sfr_pkg::*;

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    always_comb begin
        n_byte = i_ctrl.shift ? i_byte : r_byte;
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    // compare held byte against every pattern position
    always_comb begin
        for (int d = 0; d < PAT_LEN; d++) begin
            o_eq[d] = byte_eq(r_byte, i_pattern[8*d +: 8], i_ctrl.fold_case);
        end
    end

    assign o_byte = r_byte;

endmodule

### rtl/sfr_out_cell.sv
module sfr_out_cell (
    input  logic               i_clk,
    input  sfr_pkg::t_out_ctrl i_ctrl,
    input  logic [7:0]         i_load_byte,
    input  logic [7:0]         i_next_byte,
    output logic [7:0]         o_byte
);
    import sfr_pkg::*;

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    always_comb begin
        priority if (i_ctrl.load) begin
            n_byte = i_load_byte;
        end else if (i_ctrl.shift) begin
            n_byte = i_next_byte;
        end else begin
            n_byte = r_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;

endmodule

### rtl/stream_find_replace_top.sv
// Streaming find and replace over a byte stream.
// Input stream: one text byte per transfer in tdata; tuser high marks an
// end-of-stream transfer that carries no byte and flushes held bytes.
// Output stream: rewritten bytes in tdata; tlast marks the final byte
// caused by one input transfer. An input that only extends a partial match
// produces no output transfer at all.
// Configuration: write enable, register index and data; the user must write
// only while the stream is idle, the block does not enforce it. Indexes:
// find length, find pattern, replace length, replace text, first line, last
// line, fold case. Latency: the first byte caused by an input appears in the
// cycle after its transfer. The window is a shift row of byte cells with one
// compare per pattern position, so one input is taken every cycle while each
// input causes at most one byte. An input causing more bytes blocks the input
// side; the next input is taken in the cycle its last byte leaves.
// Reset: window empty, line counter zero, output row empty, registers at
// their defaults. When the receiver stalls, the output byte holds and the
// input side stops until the last waiting output byte is taken.
module stream_find_replace_top #(
    parameter int MAX_FIND_LEN    = 8,
    parameter int MAX_REPLACE_LEN = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // in_byte
    input  logic                          i_s_tuser,   // stream_end
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [7:0]                    o_m_tdata,   // out_byte
    output logic                          o_m_tlast,
    input  logic                          i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sfr_pkg::REG_W-1:0]     i_cfg_data
);
    import sfr_pkg::*;

    localparam int CW        = $clog2(MAX_FIND_LEN + 1);
    localparam int OUT_DEPTH = (MAX_FIND_LEN > MAX_REPLACE_LEN) ? MAX_FIND_LEN
                                                                : MAX_REPLACE_LEN;
    localparam int OW        = $clog2(OUT_DEPTH + 1);
    localparam int PAT_W     = 8 * MAX_FIND_LEN;

    // configuration registers
    logic [LEN_W-1:0]  r_find_len,  n_find_len;
    logic [PAT_W-1:0]  r_find_pat,  n_find_pat;
    logic [LEN_W-1:0]  r_repl_len,  n_repl_len;
    logic [REG_W-1:0]  r_repl_text, n_repl_text;
    logic [LINE_W-1:0] r_first,     n_first;
    logic [LINE_W-1:0] r_last,      n_last;
    logic              r_fold,      n_fold;

    // stream state
    logic [CW-1:0]     r_held, n_held;
    logic [LINE_W-1:0] r_line, n_line;
    logic [OW-1:0]     r_ocnt, n_ocnt;

    logic [7:0]              w_v  [MAX_FIND_LEN];
    logic [MAX_FIND_LEN-1:0] w_eq [MAX_FIND_LEN];
    logic [7:0]              w_e  [OUT_DEPTH];
    logic [7:0]              w_ob [OUT_DEPTH];

    logic [LEN_W-1:0] w_efl, w_erl, w_rcnt;
    logic [CW-1:0]    w_m, w_cnt;
    logic [OW-1:0]    w_total;
    logic             w_nl, w_in_range, w_flush_all;
    logic             w_s_xfer, w_m_xfer, w_load, w_s_ready;
    t_win_ctrl        w_win_ctrl;
    t_out_ctrl        w_out_ctrl;

    // configuration writes
    always_comb begin
        n_find_len  = r_find_len;
        n_find_pat  = r_find_pat;
        n_repl_len  = r_repl_len;
        n_repl_text = r_repl_text;
        n_first     = r_first;
        n_last      = r_last;
        n_fold      = r_fold;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FIND_LEN:   n_find_len  = i_cfg_data[LEN_W-1:0];
                CFG_FIND_PAT:   n_find_pat  = i_cfg_data[PAT_W-1:0];
                CFG_REPL_LEN:   n_repl_len  = i_cfg_data[LEN_W-1:0];
                CFG_REPL_TEXT:  n_repl_text = i_cfg_data;
                CFG_FIRST_LINE: n_first     = i_cfg_data[LINE_W-1:0];
                CFG_LAST_LINE:  n_last      = i_cfg_data[LINE_W-1:0];
                CFG_FOLD_CASE:  n_fold      = i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // effective lengths
    always_comb begin
        priority if (r_find_len == '0) begin
            w_efl = LEN_W'(1);
        end else if (r_find_len > LEN_W'(MAX_FIND_LEN)) begin
            w_efl = LEN_W'(MAX_FIND_LEN);
        end else begin
            w_efl = r_find_len;
        end
        if (r_repl_len > LEN_W'(MAX_REPLACE_LEN)) begin
            w_erl = LEN_W'(MAX_REPLACE_LEN);
        end else begin
            w_erl = r_repl_len;
        end
    end

    // window row: position 0 is the incoming byte, higher positions are older
    assign w_win_ctrl.shift     = w_s_xfer;
    assign w_win_ctrl.fold_case = r_fold;
    assign w_v[0]               = i_s_tdata;

    always_comb begin
        for (int d = 0; d < MAX_FIND_LEN; d++) begin
            w_eq[0][d] = byte_eq(i_s_tdata, r_find_pat[8*d +: 8], r_fold);
        end
    end

    for (genvar i = 1; i < MAX_FIND_LEN; i++) begin : g_win
        sfr_win_cell #(
            .PAT_LEN (MAX_FIND_LEN)
        ) u_win_cell (
            .i_clk     (i_clk),
            .i_ctrl    (w_win_ctrl),
            .i_byte    (w_v[i-1]),
            .i_pattern (r_find_pat),
            .o_byte    (w_v[i]),
            .o_eq      (w_eq[i])
        );
    end

    // longest window suffix that is a pattern prefix
    always_comb begin
        logic ok;
        w_m = '0;
        for (int m = 1; m <= MAX_FIND_LEN; m++) begin
            ok = 1'b1;
            for (int i = 0; i < m; i++) begin
                ok = ok & w_eq[i][m-1-i];
            end
            if (ok && m <= int'(r_held) + 1) begin
                w_m = CW'(m);
            end
        end
    end

    assign w_nl        = !i_s_tuser && (i_s_tdata == NEWLINE_BYTE);
    assign w_in_range  = (r_line >= r_first) && (r_line <= r_last);
    assign w_flush_all = w_nl || !w_in_range || (LEN_W'(r_held) >= w_efl);

    always_comb begin
        w_rcnt = '0;
        priority if (i_s_tuser) begin
            w_cnt  = r_held;
            n_held = '0;
        end else if (w_flush_all) begin
            w_cnt  = r_held + CW'(1);
            n_held = '0;
        end else begin
            w_cnt = r_held + CW'(1) - w_m;
            if (LEN_W'(w_m) == w_efl) begin
                w_rcnt = w_erl;
                n_held = '0;
            end else begin
                n_held = w_m;
            end
        end
    end

    assign w_total = OW'(w_cnt) + OW'(w_rcnt);

    // result list: released bytes oldest first, then the replacement
    always_comb begin
        for (int j = 0; j < OUT_DEPTH; j++) begin
            w_e[j] = '0;
            for (int i = 0; i < MAX_FIND_LEN; i++) begin
                if (j < int'(w_cnt) && i == int'(r_held) - j) begin
                    w_e[j] = w_v[i];
                end
            end
            for (int r = 0; r < MAX_REPLACE_LEN; r++) begin
                if (r < int'(w_rcnt) && j == int'(w_cnt) + r) begin
                    w_e[j] = r_repl_text[8*r +: 8];
                end
            end
        end
    end

    // handshakes
    assign w_s_ready  = (r_ocnt == '0) || ((r_ocnt == OW'(1)) && i_m_tready);
    assign w_s_xfer   = i_s_tvalid && w_s_ready;
    assign w_m_xfer   = (r_ocnt != '0) && i_m_tready;
    assign w_load     = w_s_xfer && (w_total != '0);
    assign w_out_ctrl.load  = w_load;
    assign w_out_ctrl.shift = w_m_xfer;

    always_comb begin
        n_line = r_line;
        if (w_s_xfer && w_nl && r_line != LINE_MAX) begin
            n_line = r_line + LINE_W'(1);
        end
        priority if (w_load) begin
            n_ocnt = w_total;
        end else if (w_m_xfer) begin
            n_ocnt = r_ocnt - OW'(1);
        end else begin
            n_ocnt = r_ocnt;
        end
    end

    // output row, cell 0 drives the stream
    for (genvar k = 0; k < OUT_DEPTH; k++) begin : g_out
        logic [7:0] w_next;
        if (k < OUT_DEPTH - 1) begin : g_mid
            assign w_next = w_ob[k+1];
        end else begin : g_end
            assign w_next = '0;
        end
        sfr_out_cell u_out_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_out_ctrl),
            .i_load_byte (w_e[k]),
            .i_next_byte (w_next),
            .o_byte      (w_ob[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_find_len  <= LEN_W'(1);
            r_find_pat  <= '0;
            r_repl_len  <= '0;
            r_repl_text <= '0;
            r_first     <= '0;
            r_last      <= LINE_MAX;
            r_fold      <= 1'b0;
            r_held      <= '0;
            r_line      <= '0;
            r_ocnt      <= '0;
        end else begin
            r_find_len  <= n_find_len;
            r_find_pat  <= n_find_pat;
            r_repl_len  <= n_repl_len;
            r_repl_text <= n_repl_text;
            r_first     <= n_first;
            r_last      <= n_last;
            r_fold      <= n_fold;
            if (w_s_xfer) begin
                r_held <= n_held;
            end
            r_line      <= n_line;
            r_ocnt      <= n_ocnt;
        end
    end

    assign o_s_tready = w_s_ready;
    assign o_m_tvalid = (r_ocnt != '0);
    assign o_m_tdata  = w_ob[0];
    assign o_m_tlast  = (r_ocnt == OW'(1));

endmodule

### rtl/sfr_checker.sv
module sfr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic [7:0]                    i_s_tdata,
    input logic                          i_s_tuser,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [7:0]                    o_m_tdata,
    input logic                          o_m_tlast
);
    import sfr_pkg::*;

    // stalled output transfer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast))
        else $error("output changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // a newline always releases at least itself
    a_newline_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !i_s_tuser && (i_s_tdata == NEWLINE_BYTE)
            |=> o_m_tvalid)
        else $error("newline produced no output");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    a_burst_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("input taken mid burst");

endmodule

bind stream_find_replace_top sfr_checker u_sfr_checker (.*);

### tb/tb_stream_find_replace_top.sv
module tb_stream_find_replace_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_byte;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [7:0]           i_s_tdata   = '0;
    logic                 i_s_tuser   = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [7:0]           o_m_tdata;
    logic                 o_m_tlast;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [REG_W-1:0]     i_cfg_data  = '0;

    // register copies
    logic [3:0]        m_find_len   = 4'd1;
    logic [63:0]       m_find_pat   = '0;
    logic [3:0]        m_repl_len   = 4'd0;
    logic [63:0]       m_repl_text  = '0;
    logic [LINE_W-1:0] m_first_line = '0;
    logic [LINE_W-1:0] m_last_line  = LINE_MAX;
    logic              m_fold       = 1'b0;

    // window and line state
    logic [7:0]        win_bytes [8];
    int unsigned       win_count = 0;
    logic [LINE_W-1:0] line_cnt  = '0;

    t_out_byte   expected_bytes [$];
    logic [7:0]  step_bytes [$];
    int          mismatches   = 0;
    int          stall_cycles = 0;
    bit          steady       = 1'b0;

    stream_find_replace_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // in_byte
        .i_s_tuser   (i_s_tuser),   // stream_end
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),   // out_byte
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (m_fold && c >= "A" && c <= "Z") begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic int unsigned active_find_len();
        if (m_find_len == 0) begin
            return 1;
        end
        return (m_find_len > 8) ? 8 : m_find_len;
    endfunction

    function automatic bit window_matches();
        for (int i = 0; i < win_count; i++) begin
            if (to_lower(win_bytes[i]) != to_lower(m_find_pat[i*8 +: 8])) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // at most eight bytes leave per transfer
    function automatic void emit_byte(input logic [7:0] b);
        if (step_bytes.size() < 8) begin
            step_bytes.push_back(b);
        end
    endfunction

    function automatic void flush_window();
        for (int i = 0; i < win_count; i++) begin
            emit_byte(win_bytes[i]);
        end
        win_count = 0;
    endfunction

    task automatic rewrite_step(input logic [7:0] b, input logic eos);
        int unsigned fl;
        int unsigned rl;
        t_out_byte   item;
        fl = active_find_len();
        rl = (m_repl_len > 8) ? 8 : m_repl_len;
        step_bytes.delete();
        if (win_count > 7) begin
            win_count = 7;
        end
        if (eos) begin
            flush_window();
        end else if (b == NEWLINE_BYTE) begin
            flush_window();
            emit_byte(b);
            if (line_cnt != LINE_MAX) begin
                line_cnt++;
            end
        end else if (line_cnt < m_first_line || line_cnt > m_last_line || win_count >= fl) begin
            flush_window();
            emit_byte(b);
        end else begin
            win_bytes[win_count] = b;
            win_count++;
            while (win_count > 0 && !window_matches()) begin
                emit_byte(win_bytes[0]);
                for (int i = 1; i < win_count; i++) begin
                    win_bytes[i-1] = win_bytes[i];
                end
                win_count--;
            end
            if (win_count == fl) begin
                for (int i = 0; i < rl; i++) begin
                    emit_byte(m_repl_text[i*8 +: 8]);
                end
                win_count = 0;
            end
        end
        foreach (step_bytes[i]) begin
            item.data = step_bytes[i];
            item.last = (i == step_bytes.size() - 1);
            expected_bytes.push_back(item);
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_FIND_LEN:   m_find_len   = v[3:0];
            CFG_FIND_PAT:   m_find_pat   = v;
            CFG_REPL_LEN:   m_repl_len   = v[3:0];
            CFG_REPL_TEXT:  m_repl_text  = v;
            CFG_FIRST_LINE: m_first_line = v[LINE_W-1:0];
            CFG_LAST_LINE:  m_last_line  = v[LINE_W-1:0];
            CFG_FOLD_CASE:  m_fold       = v[0];
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [7:0] b, input logic eos);
        while (!steady && $urandom_range(99) < 31) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= eos;
        do @(posedge i_clk); while (!o_s_tready);
        rewrite_step(b, eos);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // reset pattern is one zero byte with an empty replacement
    task automatic test_defaults();
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(NEWLINE_BYTE, 1'b0);
        send_item(8'hFF, 1'b1);
        drain();
    endtask

    task automatic test_basic();
        write_reg(CFG_FIND_LEN, 64'd2);
        write_reg(CFG_FIND_PAT, 64'h6261);
        write_reg(CFG_REPL_LEN, 64'd3);
        write_reg(CFG_REPL_TEXT, 64'h5A5958);
        send_item("a", 1'b0);
        send_item("a", 1'b0);
        send_item("b", 1'b0);
        send_item("a", 1'b0);
        send_item(8'h00, 1'b1);
        drain();
    endtask

    // full-width match, then an over-long window after shrinking the pattern
    task automatic test_max_expansion();
        write_reg(CFG_FOLD_CASE, 64'd1);
        write_reg(CFG_FIND_LEN, 64'd8);
        write_reg(CFG_FIND_PAT, 64'h4867_4665_4463_4261);
        write_reg(CFG_REPL_LEN, 64'd15);
        write_reg(CFG_REPL_TEXT, {$urandom, $urandom});
        for (int i = 0; i < 8; i++) begin
            send_item(m_find_pat[i*8 +: 8] ^ 8'h20, 1'b0);
        end
        for (int i = 0; i < 7; i++) begin
            send_item(m_find_pat[i*8 +: 8], 1'b0);
        end
        drain();
        write_reg(CFG_FIND_LEN, 64'd0);
        send_item("[", 1'b0);
        drain();
    endtask

    task automatic test_line_range();
        write_reg(CFG_FOLD_CASE, 64'd0);
        write_reg(CFG_FIND_LEN, 64'd2);
        write_reg(CFG_FIND_PAT, 64'h6261);
        write_reg(CFG_REPL_LEN, 64'd1);
        write_reg(CFG_REPL_TEXT, 64'h5A);
        write_reg(CFG_FIRST_LINE, 64'(line_cnt + 1));
        write_reg(CFG_LAST_LINE, 64'(line_cnt + 1));
        send_item("a", 1'b0);
        send_item(NEWLINE_BYTE, 1'b0);
        send_item("a", 1'b0);
        drain();
        write_reg(CFG_FIRST_LINE, 64'(line_cnt + 1));
        send_item("b", 1'b0);
        send_item(8'h5A, 1'b1);
        drain();
    endtask

    task automatic randomise_config(input int p);
        logic [63:0]       pat;
        logic [LINE_W-1:0] first;
        logic [LINE_W-1:0] last;
        for (int i = 0; i < 8; i++) begin
            case ($urandom_range(4))
                0: pat[i*8 +: 8] = "a";
                1: pat[i*8 +: 8] = "b";
                2: pat[i*8 +: 8] = "A";
                3: pat[i*8 +: 8] = "B";
                default: pat[i*8 +: 8] = 8'($urandom);
            endcase
        end
        if (p == 4) begin
            pat[$urandom_range(1)*8 +: 8] = NEWLINE_BYTE;
        end
        case (p)
            0: begin
                first = '0;
                last  = LINE_MAX;
            end
            1: begin
                first = LINE_W'(line_cnt + 1);
                last  = LINE_W'(line_cnt + 2);
            end
            2: begin
                first = LINE_W'(line_cnt + 3);
                last  = line_cnt;
            end
            3: begin
                first = '0;
                last  = '0;
            end
            default: begin
                first = LINE_W'(line_cnt + $urandom_range(2));
                last  = $urandom_range(1) ? LINE_MAX
                                          : LINE_W'(first + $urandom_range(3));
            end
        endcase
        write_reg(CFG_FIND_LEN, 64'(($urandom_range(3) == 0) ? $urandom_range(15)
                                                             : $urandom_range(1, 8)));
        write_reg(CFG_FIND_PAT, pat);
        write_reg(CFG_REPL_LEN, 64'(($urandom_range(3) == 0) ? $urandom_range(15)
                                                             : $urandom_range(8)));
        write_reg(CFG_REPL_TEXT, {$urandom, $urandom});
        write_reg(CFG_FIRST_LINE, 64'(first));
        write_reg(CFG_LAST_LINE, 64'(last));
        write_reg(CFG_FOLD_CASE, 64'($urandom_range(1)));
    endtask

    // mostly pattern prefixes, with random case when folding, mixed with noise, line breaks and stream ends
    task automatic random_text(input int count);
        int          n;
        int          r;
        int unsigned len;
        logic [7:0]  b;
        n = 0;
        while (n < count) begin
            r = $urandom_range(99);
            if (r < 55) begin
                len = $urandom_range(1, active_find_len());
                for (int i = 0; i < len; i++) begin
                    b = m_find_pat[i*8 +: 8];
                    if (m_fold && $urandom_range(1) && (b | 8'h20) >= "a"
                            && (b | 8'h20) <= "z") begin
                        b = b ^ 8'h20;
                    end
                    send_item(b, 1'b0);
                end
                n += len;
            end else begin
                if (r < 65) begin
                    send_item(NEWLINE_BYTE, 1'b0);
                end else if (r < 69) begin
                    send_item(8'($urandom), 1'b1);
                end else if (r < 80) begin
                    send_item($urandom_range(1) ? "a" : "B", 1'b0);
                end else begin
                    send_item(8'($urandom), 1'b0);
                end
                n++;
            end
        end
    endtask

    task automatic test_random_text();
        for (int p = 0; p < 6; p++) begin
            steady = (p == 1);
            randomise_config(p);
            random_text(40);
            drain();
        end
        steady = 1'b0;
    endtask

    always @(posedge i_clk) begin : check_output
        t_out_byte want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected output transfer: byte %h last %b",
                             o_m_tdata, o_m_tlast);
                end
            end else begin
                want = expected_bytes.pop_front();
                if (o_m_tdata !== want.data || o_m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("output byte %h last %b, expected byte %h last %b",
                                 o_m_tdata, o_m_tlast, want.data, want.last);
                    end
                end
            end
        end
        i_m_tready <= steady || ($urandom_range(99) >= 31);
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("stream_find_replace_top: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_basic();
        test_max_expansion();
        test_line_range();
        test_random_text();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("stream_find_replace_top: match");
        end else begin
            $display("stream_find_replace_top: mismatch");
        end
        $finish;
    end

endmodule
